// File: rtl/rbsi_pkg.sv
// Shared types, constants and helpers for the ray versus box slab intersection block.
package rbsi_pkg;

   localparam int DefaultFracBits = 16;
   localparam int WordWidth = 32;
   localparam int CsrIndexWidth = 3;

   localparam logic [CsrIndexWidth-1:0] CsrBoxMinX = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrBoxMinY = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrBoxMinZ = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrBoxMaxX = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrBoxMaxY = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CsrBoxMaxZ = 3'd5;

   localparam logic signed [WordWidth-1:0] S32Max = 32'sh7fff_ffff;
   localparam logic signed [WordWidth-1:0] S32Min = 32'sh8000_0000;

   typedef logic signed [WordWidth-1:0] word_type;

   // Box corners held in configuration registers.
   typedef struct packed {
      word_type min_x;
      word_type min_y;
      word_type min_z;
      word_type max_x;
      word_type max_y;
      word_type max_z;
   } box_type;

   // One ray as carried down the pipeline.
   typedef struct packed {
      word_type org_x;
      word_type org_y;
      word_type org_z;
      word_type dir_x;
      word_type dir_y;
      word_type dir_z;
   } ray_type;

   // Result word.
   typedef struct packed {
      logic     hit;
      word_type t_entry;
      word_type point_x;
      word_type point_y;
      word_type point_z;
   } result_type;

   // Saturate a 66-bit signed value into 32 bits.
   function automatic word_type sat_word(input logic signed [65:0] v);
      word_type r;
      if (v > 66'(signed'(S32Max))) begin
         r = S32Max;
      end else if (v < 66'(signed'(S32Min))) begin
         r = S32Min;
      end else begin
         r = v[WordWidth-1:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/rbsi_div.sv
// Pipelined signed restoring divider, one quotient bit per stage, truncating toward zero.
module rbsi_div #(
   parameter int NumWidth = 66,
   parameter int DenWidth = 32,
   parameter int TagWidth = 1
) (
   input  logic                       clock,
   input  logic                       advance,
   input  logic signed [NumWidth-1:0] num,
   input  logic signed [DenWidth-1:0] den,
   input  logic [TagWidth-1:0]        tag_in,
   output logic signed [NumWidth-1:0] quot,
   output logic [TagWidth-1:0]        tag_out
);

   localparam int Steps = NumWidth;
   localparam int RemWidth = DenWidth + 1;

   logic [NumWidth-1:0] q_ff   [Steps+1];
   logic [RemWidth-1:0] r_ff   [Steps+1];
   logic [DenWidth:0]   d_ff   [Steps+1];
   logic                neg_ff [Steps+1];
   logic [TagWidth-1:0] tag_ff [Steps+1];

   logic [NumWidth-1:0] num_mag;
   logic [DenWidth:0]   den_mag;

   always_comb begin
      num_mag = num[NumWidth-1] ? (~num + 1'b1) : num;
      den_mag = den[DenWidth-1] ? (~{den[DenWidth-1], den} + 1'b1) : {1'b0, den};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q_ff[0]   <= num_mag;
         r_ff[0]   <= '0;
         d_ff[0]   <= den_mag;
         neg_ff[0] <= num[NumWidth-1] ^ den[DenWidth-1];
         tag_ff[0] <= tag_in;
      end
   end

   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic [RemWidth:0]   trial;
      logic [RemWidth-1:0] shifted;
      always_comb begin
         shifted = {r_ff[s][RemWidth-2:0], q_ff[s][NumWidth-1]};
         trial   = {1'b0, shifted} - {1'b0, d_ff[s]};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!trial[RemWidth]) begin
               r_ff[s+1] <= trial[RemWidth-1:0];
               q_ff[s+1] <= {q_ff[s][NumWidth-2:0], 1'b1};
            end else begin
               r_ff[s+1] <= shifted;
               q_ff[s+1] <= {q_ff[s][NumWidth-2:0], 1'b0};
            end
            d_ff[s+1]   <= d_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            tag_ff[s+1] <= tag_ff[s];
         end
      end
   end

   assign quot    = neg_ff[Steps] ? (~q_ff[Steps] + 1'b1) : q_ff[Steps];
   assign tag_out = tag_ff[Steps];

endmodule

// File: rtl/rbsi_slab.sv
// One axis: two slab quotients through dividers, ordered, with the zero-direction check.
module rbsi_slab #(
   parameter int FracBits = rbsi_pkg::DefaultFracBits
) (
   input  logic              clock,
   input  logic              advance,
   input  rbsi_pkg::word_type org,
   input  rbsi_pkg::word_type dir,
   input  rbsi_pkg::word_type lo,
   input  rbsi_pkg::word_type hi,
   output rbsi_pkg::word_type t_lo,
   output rbsi_pkg::word_type t_hi,
   output logic              skip,
   output logic              miss
);
   import rbsi_pkg::*;

   localparam int NumWidth = 66;

   logic signed [NumWidth-1:0] num_lo, num_hi, q_lo, q_hi;
   word_type                   den;
   logic [1:0]                 tag_in, tag_out, tag_unused;
   word_type                   a, b;
   word_type                   t_lo_in, t_hi_in, t_lo_ff, t_hi_ff;
   logic                       skip_in, miss_in, skip_ff, miss_ff;

   always_comb begin
      num_lo = (NumWidth'(lo) - NumWidth'(org)) <<< FracBits;
      num_hi = (NumWidth'(hi) - NumWidth'(org)) <<< FracBits;
      den    = (dir == '0) ? word_type'(1) : dir;
      tag_in = {dir == '0, (org < lo) || (org > hi)};
   end

   rbsi_div #(.NumWidth(NumWidth), .DenWidth(WordWidth), .TagWidth(2)) u_div_lo (
      .clock(clock), .advance(advance),
      .num(num_lo), .den(den), .tag_in(tag_in), .quot(q_lo), .tag_out(tag_out)
   );

   rbsi_div #(.NumWidth(NumWidth), .DenWidth(WordWidth), .TagWidth(2)) u_div_hi (
      .clock(clock), .advance(advance),
      .num(num_hi), .den(den), .tag_in(tag_in), .quot(q_hi), .tag_out(tag_unused)
   );

   always_comb begin
      a       = sat_word(q_lo);
      b       = sat_word(q_hi);
      t_lo_in = (b < a) ? b : a;
      t_hi_in = (b < a) ? a : b;
      skip_in = tag_out[1] | (tag_unused[1] & 1'b0);
      miss_in = tag_out[1] & tag_out[0];
   end

   // Sign fix, saturation and ordering get their own stage.
   always_ff @(posedge clock) begin
      if (advance) begin
         t_lo_ff <= t_lo_in;
         t_hi_ff <= t_hi_in;
         skip_ff <= skip_in;
         miss_ff <= miss_in;
      end
   end

   assign t_lo = t_lo_ff;
   assign t_hi = t_hi_ff;
   assign skip = skip_ff;
   assign miss = miss_ff;

endmodule

// File: rtl/ray_box_slab_intersect.sv
// Top level of the ray versus axis-aligned box slab intersection pipeline.
// Each input word is one ray (origin and direction, signed fixed point with
// FRAC_BITS fraction bits); each output word reports hit, near t and the
// entry point against the box held in six configuration registers. The block
// is a pipeline that takes one ray every clock cycle while it advances. Its
// registers are one input register, 67 stages of the bit-per-stage slab
// dividers (an entry stage and 66 quotient-bit stages), a stage that fixes
// the sign, saturates and orders the slab values, an interval merge stage,
// one stage each for the point product and the sum, and the output register.
// The whole pipeline advances only when the output register is empty or
// being read, so a stall holds every stage and no word is lost or repeated;
// the input is ready whenever the pipe advances.
// Configuration may be written only while the pipeline is empty.
module ray_box_slab_intersect #(
   parameter int FRAC_BITS = rbsi_pkg::DefaultFracBits
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (lowest bits first)
   input  logic [6*rbsi_pkg::WordWidth-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // hit, t_entry, point_x, point_y, point_z, then 7 zero bits
   output logic [4*rbsi_pkg::WordWidth+7:0]  rsp_tdata,
   input  logic                              csr_we,
   input  logic [rbsi_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [rbsi_pkg::WordWidth-1:0]    csr_wdata
);
   import rbsi_pkg::*;

   // Divider stages plus the slab ordering register.
   localparam int DivLatency = 68;
   localparam int TailStages = 3;

   box_type box_ff;
   logic    advance;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CsrBoxMinX: box_ff.min_x <= csr_wdata;
            CsrBoxMinY: box_ff.min_y <= csr_wdata;
            CsrBoxMinZ: box_ff.min_z <= csr_wdata;
            CsrBoxMaxX: box_ff.max_x <= csr_wdata;
            CsrBoxMaxY: box_ff.max_y <= csr_wdata;
            CsrBoxMaxZ: box_ff.max_z <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The output register is the only place a word can wait.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // Input register.
   ray_type ray_ff;
   logic    in_vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (advance) begin
         in_vld_ff <= req_tvalid;
      end
      if (advance) begin
         ray_ff <= ray_type'({req_tdata[31:0], req_tdata[63:32], req_tdata[95:64],
                              req_tdata[127:96], req_tdata[159:128], req_tdata[191:160]});
      end
   end

   // Per-axis slab units.
   word_type tl [3];
   word_type th [3];
   logic     sk [3];
   logic     ms [3];
   word_type org_a [3];
   word_type dir_a [3];
   word_type lo_a [3];
   word_type hi_a [3];

   always_comb begin
      org_a[0] = ray_ff.org_x; org_a[1] = ray_ff.org_y; org_a[2] = ray_ff.org_z;
      dir_a[0] = ray_ff.dir_x; dir_a[1] = ray_ff.dir_y; dir_a[2] = ray_ff.dir_z;
      lo_a[0] = box_ff.min_x; lo_a[1] = box_ff.min_y; lo_a[2] = box_ff.min_z;
      hi_a[0] = box_ff.max_x; hi_a[1] = box_ff.max_y; hi_a[2] = box_ff.max_z;
   end

   for (genvar a = 0; a < 3; a++) begin : g_axis
      rbsi_slab #(.FracBits(FRAC_BITS)) u_slab (
         .clock(clock), .advance(advance),
         .org(org_a[a]), .dir(dir_a[a]), .lo(lo_a[a]), .hi(hi_a[a]),
         .t_lo(tl[a]), .t_hi(th[a]), .skip(sk[a]), .miss(ms[a])
      );
   end

   // Valid bit and ray travel alongside the dividers.
   logic    vld_ff [DivLatency];
   ray_type dray_ff [DivLatency];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DivLatency; i++) vld_ff[i] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_vld_ff;
         for (int i = 1; i < DivLatency; i++) vld_ff[i] <= vld_ff[i-1];
      end
      if (advance) begin
         dray_ff[0] <= ray_ff;
         for (int i = 1; i < DivLatency; i++) dray_ff[i] <= dray_ff[i-1];
      end
   end

   // Interval merge: axes in order, stopping at the first miss.
   word_type near_c, far_c;
   logic     hit_c;
   always_comb begin
      near_c = S32Min;
      far_c  = S32Max;
      hit_c  = 1'b1;
      for (int a = 0; a < 3; a++) begin
         if (hit_c) begin
            if (sk[a]) begin
               if (ms[a]) hit_c = 1'b0;
            end else begin
               if (tl[a] > near_c) near_c = tl[a];
               if (th[a] < far_c) far_c = th[a];
               if ((near_c > far_c) || (far_c < 0)) hit_c = 1'b0;
            end
         end
      end
   end

   // Tail stage 0: interval result.
   logic     m_vld_ff, m_hit_ff;
   word_type m_near_ff;
   ray_type  m_ray_ff;
   // Tail stage 1: products.
   logic     p_vld_ff, p_hit_ff;
   word_type p_near_ff;
   ray_type  p_ray_ff;
   logic signed [63:0] prod_ff [3];
   // Tail stage 2: floored and summed, saturated.
   logic     s_vld_ff;
   result_type s_res_ff;
   result_type out_ff;
   logic       out_vld_ff;

   word_type pt_c [3];
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         pt_c[a] = sat_word(66'(signed'(a == 0 ? p_ray_ff.org_x :
                                       a == 1 ? p_ray_ff.org_y : p_ray_ff.org_z))
                            + 66'(prod_ff[a] >>> FRAC_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff   <= 1'b0;
         p_vld_ff   <= 1'b0;
         s_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         m_vld_ff   <= vld_ff[DivLatency-1];
         p_vld_ff   <= m_vld_ff;
         s_vld_ff   <= p_vld_ff;
         out_vld_ff <= s_vld_ff;
      end
      if (advance) begin
         m_hit_ff  <= hit_c;
         m_near_ff <= near_c;
         m_ray_ff  <= dray_ff[DivLatency-1];
         p_hit_ff  <= m_hit_ff;
         p_near_ff <= m_near_ff;
         p_ray_ff  <= m_ray_ff;
         prod_ff[0] <= m_near_ff * m_ray_ff.dir_x;
         prod_ff[1] <= m_near_ff * m_ray_ff.dir_y;
         prod_ff[2] <= m_near_ff * m_ray_ff.dir_z;
         s_res_ff.hit     <= p_hit_ff;
         s_res_ff.t_entry <= p_hit_ff ? p_near_ff : '0;
         s_res_ff.point_x <= p_hit_ff ? pt_c[0] : '0;
         s_res_ff.point_y <= p_hit_ff ? pt_c[1] : '0;
         s_res_ff.point_z <= p_hit_ff ? pt_c[2] : '0;
         out_ff <= s_res_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {7'd0, out_ff.point_z, out_ff.point_y, out_ff.point_x,
                        out_ff.t_entry, out_ff.hit};

   localparam int TailCheck = TailStages;

   // A miss always reports zeros.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[4*WordWidth:1] == '0))
      else $error("miss word carries nonzero payload");

   // A stalled output word does not change.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("output word changed while stalled");

   // The pipe only takes input when it advances.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      (req_tready == (!rsp_tvalid || rsp_tready)) && (TailCheck == 3))
      else $error("input ready does not follow pipeline advance");

endmodule
